>>> design/sopd_pkg.sv
// Shared types, constants and helpers for the distance-ordered place sorter.
// No dependencies; every other file in design/ refers to this package by scoped name.

package sopd_pkg;

  // Capacity and coordinate handling
  localparam int MAX_PLACES = 64;
  localparam int COORD_BITS = 16;
  localparam int XY_W       = 16;
  localparam int COORD_EFF  = (COORD_BITS > XY_W) ? XY_W : COORD_BITS;
  localparam int COORD_SH   = XY_W - COORD_EFF;

  // Field widths
  localparam int ID_W   = 32;
  localparam int DIST_W = 2 * XY_W;
  localparam int CNT_W  = $clog2(MAX_PLACES + 1);

  typedef logic [ID_W-1:0]         id_t;
  typedef logic signed [XY_W-1:0]  coord_t;
  typedef logic [DIST_W-1:0]       dist_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // One stored entry of the sorting row
  typedef struct packed {
    logic   valid;
    id_t    id;
    dist_t  sqd;
    coord_t y;
  } entry_t;

  // Registered input item with its squared distance
  typedef struct packed {
    logic   valid;
    logic   last;
    id_t    id;
    dist_t  sqd;
    coord_t y;
  } stage_t;

  // Row-wide control driven by the top level
  typedef struct packed {
    logic ins;    // place the staged item into the row
    logic shift;  // move every entry one cell toward the head
  } cell_ctl_t;

  // Keep the low COORD_EFF bits and sign-extend from the top one of them
  function automatic coord_t coord_value(coord_t raw);
    coord_t shl;
    shl = coord_t'(raw <<< COORD_SH);
    return coord_t'(shl >>> COORD_SH);
  endfunction

  // New key sorts ahead of the stored entry; an empty cell is always behind
  function automatic logic goes_before(dist_t d, coord_t y, entry_t e);
    coord_t ey;
    ey = e.y;
    if (!e.valid) return 1'b1;
    if (d != e.sqd) return d < e.sqd;
    return y < ey;
  endfunction

endpackage

>>> design/sopd_if.sv
// Handshake channel interfaces for the place sorter: input items and result items.
// Depends on sopd_pkg for field types.

interface sopd_in_if;
  logic            valid;
  logic            ready;
  sopd_pkg::id_t    place_id;
  sopd_pkg::coord_t place_x;
  sopd_pkg::coord_t place_y;
  logic            last_place;

  modport source (output valid, place_id, place_x, place_y, last_place, input ready);
  modport sink   (input valid, place_id, place_x, place_y, last_place, output ready);
endinterface

interface sopd_out_if;
  logic          valid;
  logic          ready;
  sopd_pkg::id_t sorted_id;
  logic          last_out;
  logic          overflow;

  modport source (output valid, sorted_id, last_out, overflow, input ready);
  modport sink   (input valid, sorted_id, last_out, overflow, output ready);
endinterface

>>> design/sopd_dist.sv
// Input stage: takes an item, squares the coordinates and registers id, distance and y.
// Depends on sopd_pkg and sopd_in_if.

module sopd_dist (
  input  logic              clk,
  input  logic              rst_n,
  sopd_in_if.sink           in_ch,
  input  logic              hold,
  output sopd_pkg::stage_t  stg
);

  logic                      stg_v_r, stg_v_nxt;
  logic                      stg_last_r;
  sopd_pkg::id_t             stg_id_r;
  sopd_pkg::dist_t           stg_dist_r;
  sopd_pkg::coord_t          stg_y_r;
  sopd_pkg::coord_t          x_c, y_c;
  logic signed [sopd_pkg::DIST_W-1:0] x_w, y_w;
  logic signed [sopd_pkg::DIST_W-1:0] xx, yy;
  sopd_pkg::dist_t           dist_c;
  logic                      accept;

  // Stop taking items while draining or while a last item waits to be placed
  assign in_ch.ready = !hold && !(stg_v_r && stg_last_r);
  assign accept      = in_ch.valid && in_ch.ready;

  // Squared distance, exact; fits DIST_W without carry
  always_comb begin
    x_c    = sopd_pkg::coord_value(in_ch.place_x);
    y_c    = sopd_pkg::coord_value(in_ch.place_y);
    x_w    = {{sopd_pkg::XY_W{x_c[sopd_pkg::XY_W-1]}}, x_c};
    y_w    = {{sopd_pkg::XY_W{y_c[sopd_pkg::XY_W-1]}}, y_c};
    xx     = x_w * x_w;
    yy     = y_w * y_w;
    dist_c = sopd_pkg::dist_t'($unsigned(xx)) + sopd_pkg::dist_t'($unsigned(yy));
  end

  // Staged item is consumed in the cycle after it lands unless the row drains
  always_comb begin
    stg_v_nxt = stg_v_r;
    if (accept) begin
      stg_v_nxt = 1'b1;
    end else if (!hold) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r    <= 1'b0;
      stg_last_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
      if (accept) begin
        stg_last_r <= in_ch.last_place;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_id_r   <= in_ch.place_id;
      stg_dist_r <= dist_c;
      stg_y_r    <= y_c;
    end
  end

  assign stg.valid = stg_v_r;
  assign stg.last  = stg_last_r;
  assign stg.id    = stg_id_r;
  assign stg.sqd   = stg_dist_r;
  assign stg.y     = stg_y_r;

endmodule

>>> design/sopd_cell.sv
// One cell of the insertion row: holds one entry, compares it to the broadcast key,
// takes the new item, its left neighbor, or its right neighbor. Depends on sopd_pkg.

module sopd_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sopd_pkg::cell_ctl_t ctl,
  input  sopd_pkg::entry_t    new_e,
  input  sopd_pkg::entry_t    left_e,
  input  logic                ahead_left,
  input  sopd_pkg::entry_t    right_e,
  output sopd_pkg::entry_t    ent,
  output logic                ahead
);

  sopd_pkg::entry_t ent_r, ent_nxt;

  // Insertion point: first cell where the new key sorts ahead
  assign ahead = sopd_pkg::goes_before(new_e.sqd, new_e.y, ent_r);

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctl.shift) begin
      ent_nxt = right_e;
    end else if (ctl.ins && ahead) begin
      ent_nxt = ahead_left ? left_e : new_e;
    end
  end

  // Only the valid bit is reset; payload follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.id  <= ent_nxt.id;
    ent_r.sqd <= ent_nxt.sqd;
    ent_r.y   <= ent_nxt.y;
  end

  assign ent = ent_r;

endmodule

>>> design/sort_points_by_origin_distance.sv
// Top level of the distance-ordered place sorter: input stage plus a row of sorting cells.
// Depends on sopd_pkg, sopd_if, sopd_dist and sopd_cell.
//
// Use: places arrive on in_ch (place_id, signed place_x/place_y, last_place). Each
// place is registered with its exact squared distance and, in the following cycle,
// dropped into its sorted slot in a row of MAX_PLACES cells, so loading runs at one
// item per clock outside a drain. Order is by x*x+y*y, then by smaller y, then arrival.
// On the item flagged last_place the set is placed as usual, and then the row
// shifts toward its head, one result on out_ch per cycle that out_ch.ready allows:
// sorted_id, last_out on the final one, overflow on all if any place was dropped.
// Once the last item leaves the stage, the drain flag is registered and raises out_ch.valid;
// in_ch.ready is low from the cycle after a last item is accepted until the final
// result of that set is taken.
// A stalled receiver simply holds the head cell; nothing is lost.
// A place arriving with the row full is discarded and marks the set as overflowed;
// the stored run is still emitted. Reset (rst_n low, synchronous) empties the row,
// clears the overflow mark and the staged item; no clearing pass is needed.

module sort_points_by_origin_distance (
  input  logic        clk,
  input  logic        rst_n,
  sopd_in_if.sink     in_ch,
  sopd_out_if.source  out_ch
);

  localparam int N = sopd_pkg::MAX_PLACES;

  sopd_pkg::stage_t     stg;
  sopd_pkg::entry_t     new_e;
  sopd_pkg::cell_ctl_t  ctl;
  sopd_pkg::entry_t     ent    [N];
  logic [N-1:0]         ahead;
  logic [N-1:0]         vld;
  sopd_pkg::cnt_t       count_r, count_nxt;
  logic                 drain_r, drain_nxt;
  logic                 drop_r, drop_nxt;
  logic                 full, out_take;

  // Input stage
  sopd_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .hold  (drain_r),
    .stg   (stg)
  );

  assign new_e.valid = 1'b1;
  assign new_e.id    = stg.id;
  assign new_e.sqd   = stg.sqd;
  assign new_e.y     = stg.y;

  assign full     = (count_r == sopd_pkg::cnt_t'(N));
  assign out_take = out_ch.valid && out_ch.ready;

  // Row control
  assign ctl.ins   = stg.valid && !drain_r && !full;
  assign ctl.shift = out_take;

  // Sorting row
  for (genvar i = 0; i < N; i++) begin : g_cell
    sopd_pkg::entry_t left_e, right_e;
    logic             ahead_left;

    if (i == 0) begin : g_head
      assign left_e     = '0;
      assign ahead_left = 1'b0;
    end else begin : g_mid
      assign left_e     = ent[i-1];
      assign ahead_left = ahead[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = ent[i+1];
    end

    sopd_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_e      (new_e),
      .left_e     (left_e),
      .ahead_left (ahead_left),
      .right_e    (right_e),
      .ent        (ent[i]),
      .ahead      (ahead[i])
    );

    assign vld[i] = ent[i].valid;
  end

  // Fill count, overflow mark and drain flag
  always_comb begin
    count_nxt = count_r;
    drain_nxt = drain_r;
    drop_nxt  = drop_r;
    if (drain_r) begin
      if (out_take) begin
        count_nxt = count_r - sopd_pkg::cnt_t'(1);
        if (count_r == sopd_pkg::cnt_t'(1)) begin
          drain_nxt = 1'b0;
          drop_nxt  = 1'b0;
        end
      end
    end else if (stg.valid) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        count_nxt = count_r + sopd_pkg::cnt_t'(1);
      end
      if (stg.last) begin
        drain_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drain_r <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drain_r <= drain_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Results come straight from the head cell
  assign out_ch.valid     = drain_r;
  assign out_ch.sorted_id = ent[0].id;
  assign out_ch.last_out  = (count_r == sopd_pkg::cnt_t'(1));
  assign out_ch.overflow  = drop_r;

  // Checks
  a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld) == int'(count_r))
    else $error("fill count disagrees with occupied cells");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (count_r != '0))
    else $error("draining an empty row");

  a_no_load_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> !in_ch.ready)
    else $error("input taken while results pending");

  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_ch.last_out) |=> (count_r == '0) && !drop_r && !drain_r)
    else $error("set not cleared after final result");

  a_head_valid_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ent[0].valid)
    else $error("result shown from an empty head cell");

endmodule

>>> dv/tb_sort_points_by_origin_distance.sv
// Testbench for the distance-ordered place sorter: drives place items, predicts each
// sorted run of ids and checks every result item. Depends on design/sopd_pkg.sv,
// design/sopd_if.sv and the top level sort_points_by_origin_distance.

module tb_sort_points_by_origin_distance;

  localparam int CYCLE_LIMIT = 300000;
  localparam int KEEP_BITS   = (sopd_pkg::COORD_BITS > 16) ? 16 : sopd_pkg::COORD_BITS;
  localparam int MAX_PLACES  = sopd_pkg::MAX_PLACES;

  // One expected result item
  typedef struct {
    sopd_pkg::id_t id;
    logic          last;
    logic          ovf;
  } sorted_out_t;

  logic clk;
  logic rst_n;

  sopd_in_if  in_if ();
  sopd_out_if out_if ();

  sort_points_by_origin_distance dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Predicted row contents for the set being loaded
  sopd_pkg::id_t   rank_id   [MAX_PLACES];
  sopd_pkg::dist_t rank_dist [MAX_PLACES];
  int              rank_y    [MAX_PLACES];
  int    rank_fill    = 0;
  bit    rank_dropped = 1'b0;

  sorted_out_t sorted_run_q[$];

  int err_cnt      = 0;
  int items_sent   = 0;
  int sets_done    = 0;
  int ovf_sets     = 0;
  int ids_checked  = 0;
  int cycle_cnt    = 0;
  int hold_req     = 0;
  bit idle_on      = 1'b1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: timeout after %0d cycles, %0d ids still expected",
             cycle_cnt, sorted_run_q.size());
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("tb: mismatch: %s", msg);
    err_cnt++;
  endtask

  // Keep the low coordinate bits and sign-extend from the top one of them
  function automatic int coord_sext(sopd_pkg::coord_t raw);
    logic [15:0] kept;
    int v;
    kept = 16'(raw) & 16'((17'd1 << KEEP_BITS) - 17'd1);
    v = int'(kept);
    if (kept[KEEP_BITS-1]) v -= (1 << KEEP_BITS);
    return v;
  endfunction

  // Insert one accepted place into the predicted row; on last, queue the run
  task automatic rank_place(sopd_pkg::id_t id, sopd_pkg::coord_t x_raw,
                            sopd_pkg::coord_t y_raw, logic last);
    int xs, ys, pos;
    longint ax, ay;
    sopd_pkg::dist_t d;
    sorted_out_t r;
    xs = coord_sext(x_raw);
    ys = coord_sext(y_raw);
    ax = (xs < 0) ? -xs : xs;
    ay = (ys < 0) ? -ys : ys;
    d = sopd_pkg::dist_t'(ax * ax + ay * ay);
    if (rank_fill >= MAX_PLACES) begin
      rank_dropped = 1'b1;
    end else begin
      pos = rank_fill;
      // walk toward the head past every entry the new key sorts ahead of
      while (pos > 0 && ((d < rank_dist[pos-1]) ||
                         (d == rank_dist[pos-1] && ys < rank_y[pos-1]))) begin
        rank_id[pos]   = rank_id[pos-1];
        rank_dist[pos] = rank_dist[pos-1];
        rank_y[pos]    = rank_y[pos-1];
        pos--;
      end
      rank_id[pos]   = id;
      rank_dist[pos] = d;
      rank_y[pos]    = ys;
      rank_fill++;
    end
    if (last) begin
      for (int k = 0; k < rank_fill; k++) begin
        r.id   = rank_id[k];
        r.last = (k == rank_fill - 1);
        r.ovf  = rank_dropped;
        sorted_run_q = {sorted_run_q, r};
      end
      sets_done++;
      if (rank_dropped) ovf_sets++;
      rank_fill    = 0;
      rank_dropped = 1'b0;
    end
  endtask

  // Compare one accepted result item with the oldest expectation
  task automatic check_sorted_result();
    sorted_out_t e;
    if (sorted_run_q.size() == 0) begin
      report_mismatch($sformatf("id %08h arrived with nothing expected", out_if.sorted_id));
    end else begin
      e = sorted_run_q.pop_front();
      ids_checked++;
      if (out_if.sorted_id !== e.id)
        report_mismatch($sformatf("sorted_id %08h, expected %08h", out_if.sorted_id, e.id));
      if (out_if.last_out !== e.last)
        report_mismatch($sformatf("last_out %b, expected %b on id %08h",
                                  out_if.last_out, e.last, e.id));
      if (out_if.overflow !== e.ovf)
        report_mismatch($sformatf("overflow %b, expected %b on id %08h",
                                  out_if.overflow, e.ovf, e.id));
    end
  endtask

  // Result side: check accepted items, drive ready with holds and random stalls
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) check_sorted_result();
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_req > 0) begin
        out_if.ready <= 1'b0;
        hold_req--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one place item, with an optional idle burst ahead of it
  task automatic send_place(sopd_pkg::id_t id, sopd_pkg::coord_t x,
                            sopd_pkg::coord_t y, logic last);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.place_id   <= id;
    in_if.place_x    <= x;
    in_if.place_y    <= y;
    in_if.last_place <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    rank_place(id, x, y, last);
  endtask

  // Same, with coordinates given as plain integers
  task automatic send_xy(sopd_pkg::id_t id, int x, int y, logic last);
    send_place(id, sopd_pkg::coord_t'(x), sopd_pkg::coord_t'(y), last);
  endtask

  // Stop offering and wait until every predicted id has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sorted_run_q.size() != 0);
  endtask

  // spread: 0 full range, 1 tiny (many ties), 2 extremes, 3 moderate, 4 mixed
  function automatic sopd_pkg::coord_t pick_coord(int spread);
    int s;
    s = (spread == 4) ? int'($urandom_range(0, 3)) : spread;
    case (s)
      0: return sopd_pkg::coord_t'($urandom);
      1: return sopd_pkg::coord_t'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 5))
          0: return sopd_pkg::coord_t'(-32768);
          1: return sopd_pkg::coord_t'(-32767);
          2: return sopd_pkg::coord_t'(-1);
          3: return sopd_pkg::coord_t'(0);
          4: return sopd_pkg::coord_t'(1);
          default: return sopd_pkg::coord_t'(32767);
        endcase
      end
      default: return sopd_pkg::coord_t'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  task automatic send_random_set(int n, int spread);
    sopd_pkg::id_t id;
    for (int k = 0; k < n; k++) begin
      id = ($urandom_range(0, 3) == 0) ? sopd_pkg::id_t'($urandom_range(0, 15))
                                        : sopd_pkg::id_t'($urandom);
      send_place(id, pick_coord(spread), pick_coord(spread), k == n - 1);
    end
  endtask

  // Equal distances: smaller y first, equal y in arrival order
  task automatic test_tie_order();
    send_xy(32'h0000_0010,  3,  4, 1'b0);
    send_xy(32'h0000_0011,  4,  3, 1'b0);
    send_xy(32'h0000_0012, -3, -4, 1'b0);
    send_xy(32'h0000_0013,  5,  0, 1'b0);
    send_xy(32'h0000_0014,  0, -5, 1'b0);
    send_xy(32'h0000_0015,  0,  5, 1'b0);
    send_xy(32'h0000_0016, -5,  0, 1'b0);
    send_xy(32'h0000_0017, -4,  3, 1'b1);
  endtask

  // Field extremes: corner coordinates, all-ones and all-zero ids
  task automatic test_extremes();
    send_xy(32'hFFFF_FFFF, -32768, -32768, 1'b0);
    send_xy(32'h0000_0000,  32767,  32767, 1'b0);
    send_xy(32'h8000_0001,      0,      0, 1'b0);
    send_xy(32'h7FFF_FFFE, -32768,  32767, 1'b0);
    send_xy(32'h5555_AAAA,      1,     -1, 1'b0);
    send_xy(32'hAAAA_5555,     -1,      1, 1'b1);
  endtask

  // A set of one, then the same point loaded three times
  task automatic test_single_and_repeat();
    send_xy(32'h0000_0020, 100, -200, 1'b1);
    send_xy(32'h0000_0021,   7,   -7, 1'b0);
    send_xy(32'h0000_0022,   7,   -7, 1'b0);
    send_xy(32'h0000_0023,   7,   -7, 1'b1);
  endtask

  task automatic test_random_sets();
    int n;
    while (items_sent < 120) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_set(n, $urandom_range(0, 4));
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
  endtask

  // Exactly full, then past full (last item dropped too), then a clean set
  task automatic test_full_and_overflow();
    send_random_set(MAX_PLACES, 4);
    send_random_set(MAX_PLACES + 2, 1);
    send_random_set(3, 0);
  endtask

  // Receiver holds off long while sets keep coming; input must stall
  task automatic test_output_hold();
    hold_req = 200;
    repeat (3) send_random_set(10, 4);
  endtask

  task automatic test_no_idle();
    int start;
    idle_on = 1'b0;
    start = items_sent;
    while (items_sent - start < 40) send_random_set($urandom_range(1, 8), 4);
  endtask

  initial begin : main_seq
    in_if.valid      <= 1'b0;
    in_if.place_id   <= '0;
    in_if.place_x    <= '0;
    in_if.place_y    <= '0;
    in_if.last_place <= 1'b0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_tie_order();
    test_extremes();
    test_single_and_repeat();
    wait_drained();
    test_random_sets();
    wait_drained();
    test_full_and_overflow();
    wait_drained();
    test_output_hold();
    wait_drained();
    test_no_idle();
    wait_drained();

    repeat (10) @(posedge clk);
    if (sorted_run_q.size() != 0)
      report_mismatch($sformatf("%0d ids never arrived", sorted_run_q.size()));
    $display("tb: %0d places loaded in %0d sets (%0d overflowed), %0d sorted ids checked",
             items_sent, sets_done, ovf_sets, ids_checked);
    $display("tb: ties, coordinate extremes, full row, long output hold, no-idle streaming");
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
design/sopd_pkg.sv
design/sopd_if.sv
design/sopd_dist.sv
design/sopd_cell.sv
design/sort_points_by_origin_distance.sv
dv/tb_sort_points_by_origin_distance.sv
